>>> design/chse_pkg.sv
// Shared types and constants for the cubic Hermite spline evaluator.
`default_nettype none
package chse_pkg;
   localparam int MAX_KNOTS = 64;
   localparam int KNOT_AW   = $clog2(MAX_KNOTS);
   localparam int CNT_W     = 7;
   localparam int TIME_W    = 32;
   localparam int VAL_W     = 32;
   localparam int WORD_W    = TIME_W + 2 * VAL_W + 1;
   localparam int Q_W       = 31;
   localparam int DIV_CNT_W = 5;
   localparam int DIV_LAST  = Q_W - 1;
   localparam int MUL_W     = 36;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int ACC_W     = 54;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BEFORE = 2'd1,
      ST_PAST   = 2'd2,
      ST_ZERO   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      MUL_SS, MUL_S2S, MUL_PH, MUL_M0G0, MUL_A0D, MUL_M1G1, MUL_A1D
   } mul_sel_type;

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_SCAN, S_CHECK, S_DIV, S_MUL, S_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic                 load_req;
      logic                 mem_wr;
      logic                 mem_rd;
      logic [KNOT_AW-1:0]   rd_addr;
      logic                 shift;
      logic                 div_init;
      logic                 div_step;
      logic                 mul_en;
      logic                 take_en;
      mul_sel_type          mul_sel;
      logic                 rsp_load;
      status_type           rsp_status;
      logic                 rsp_use_value;
      logic [KNOT_AW-1:0]   rsp_seg;
   } dp_cmd_type;

   typedef struct packed {
      logic                 is_write;
      logic [KNOT_AW-1:0]   wr_index;
      logic                 q_lt;
      logic                 q_eq;
      logic                 zero_len;
   } dp_stat_type;
endpackage
`default_nettype wire

>>> design/chse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module chse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> design/chse_ctrl.sv
// Controller state machine: knot search, divider and multiply sequencing.
`default_nettype none
module chse_ctrl import chse_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [CNT_W-1:0] csr_wr_data,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output dp_cmd_type            cmd,
   input  wire dp_stat_type      stat
);
   ctrl_state_type       state_ff, state_in;
   logic [CNT_W-1:0]     knot_count_ff;
   logic [KNOT_AW-1:0]   rd_idx_ff, rd_idx_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   mul_sel_type          step_ff, step_in;
   logic                 phase_ff, phase_in;
   logic [KNOT_AW-1:0]   seg_ff, seg_in;
   status_type           status_ff, status_in;
   logic                 use_val_ff, use_val_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KNOT_AW-1:0]   last_idx;
   logic                 out_free;

   always_comb begin
      priority if (knot_count_ff < CNT_W'(2)) begin
         last_idx = KNOT_AW'(1);
      end else if (knot_count_ff > CNT_W'(MAX_KNOTS)) begin
         last_idx = KNOT_AW'(MAX_KNOTS - 1);
      end else begin
         last_idx = KNOT_AW'(knot_count_ff - CNT_W'(1));
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state and sequencing counters.
   always_comb begin
      state_in   = state_ff;
      rd_idx_in  = rd_idx_ff;
      div_cnt_in = div_cnt_ff;
      step_in    = step_ff;
      phase_in   = phase_ff;
      seg_in     = seg_ff;
      status_in  = status_ff;
      use_val_in = use_val_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_START;
            end
         end
         S_START: begin
            rd_idx_in = '0;
            if (stat.is_write) begin
               seg_in     = stat.wr_index;
               status_in  = ST_OK;
               use_val_in = 1'b0;
               state_in   = S_RESP;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            use_val_in = 1'b0;
            priority if (rd_idx_ff == '0) begin
               if (stat.q_lt) begin
                  seg_in    = '0;
                  status_in = ST_BEFORE;
                  state_in  = S_RESP;
               end else begin
                  rd_idx_in = rd_idx_ff + KNOT_AW'(1);
               end
            end else if (stat.q_lt) begin
               seg_in   = rd_idx_ff;
               state_in = S_CHECK;
            end else if (rd_idx_ff == last_idx) begin
               seg_in = last_idx;
               if (stat.q_eq) begin
                  state_in = S_CHECK;
               end else begin
                  status_in = ST_PAST;
                  state_in  = S_RESP;
               end
            end else begin
               rd_idx_in = rd_idx_ff + KNOT_AW'(1);
            end
         end
         S_CHECK: begin
            div_cnt_in = '0;
            if (stat.zero_len) begin
               status_in = ST_ZERO;
               state_in  = S_RESP;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_LAST)) begin
               step_in  = MUL_SS;
               phase_in = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (step_ff == MUL_A1D) begin
                  status_in  = ST_OK;
                  use_val_in = 1'b1;
                  state_in   = S_RESP;
               end else begin
                  step_in = mul_sel_type'(step_ff + 3'd1);
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd               = '0;
      cmd.mul_sel       = step_ff;
      cmd.rsp_status    = status_ff;
      cmd.rsp_use_value = use_val_ff;
      cmd.rsp_seg       = seg_ff;
      req_tready        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         S_START: begin
            cmd.mem_wr  = stat.is_write;
            cmd.mem_rd  = !stat.is_write;
            cmd.rd_addr = '0;
         end
         S_SCAN: begin
            cmd.shift   = 1'b1;
            cmd.mem_rd  = 1'b1;
            cmd.rd_addr = rd_idx_ff + KNOT_AW'(1);
         end
         S_CHECK: cmd.div_init = 1'b1;
         S_DIV:   cmd.div_step = 1'b1;
         S_MUL: begin
            cmd.mul_en  = !phase_ff;
            cmd.take_en = phase_ff;
         end
         S_RESP:  cmd.rsp_load = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         knot_count_ff <= CNT_W'(2);
         rsp_valid_ff  <= 1'b0;
         rd_idx_ff     <= '0;
         div_cnt_ff    <= '0;
         step_ff       <= MUL_SS;
         phase_ff      <= 1'b0;
         seg_ff        <= '0;
         status_ff     <= ST_OK;
         use_val_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_idx_ff    <= rd_idx_in;
         div_cnt_ff   <= div_cnt_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         seg_ff       <= seg_in;
         status_ff    <= status_in;
         use_val_ff   <= use_val_in;
         if (csr_wr_en) begin
            knot_count_ff <= csr_wr_data;
         end
      end
   end
endmodule
`default_nettype wire

>>> design/chse_dp.sv
// Datapath: knot table, divider, shared multiplier and result register.
`default_nettype none
module chse_dp import chse_pkg::*; (
   input  wire logic                  clock,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   input  wire dp_cmd_type            cmd,
   output dp_stat_type                stat,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic      [1:0]            rsp_tuser
);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh8000_0000);

   logic                     op_ff;
   logic [KNOT_AW-1:0]       idx_ff;
   logic [WORD_W-1:0]        wword_ff;
   logic [TIME_W-1:0]        q_ff;
   logic [WORD_W-1:0]        rd_word, lo_ff, hi_ff;
   logic [TIME_W-1:0]        d_ff;
   logic [TIME_W:0]          rem_ff;
   logic [Q_W-1:0]           quo_ff, s2_ff, s3_ff;
   logic                     first_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [MUL_W-1:0]  a_ff, opa, opb;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [VAL_W-1:0]         value_ff;
   logic [KNOT_AW-1:0]       seg_ff;
   status_type               status_ff;

   logic [TIME_W-1:0]        lo_t, hi_t, rd_t, d_new, tau;
   logic [TIME_W:0]          shifted;
   logic                     ge;
   logic signed [33:0]       s_e, s2_e, s3_e, h, g0, g1;
   logic signed [32:0]       diff;
   logic signed [VAL_W-1:0]  m0, m1;
   logic signed [PROD_W-1:0] sh18, sh28, sh30;
   logic [VAL_W-1:0]         sat;

   chse_ram #(.WIDTH(WORD_W), .DEPTH(MAX_KNOTS)) u_knots (
      .clock   (clock),
      .wr_en   (cmd.mem_wr),
      .wr_addr (idx_ff),
      .wr_data (wword_ff),
      .rd_en   (cmd.mem_rd),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_word)
   );

   // Knot word: time lowest, then position, slope, and the slope flag on top.
   assign rd_t = rd_word[TIME_W-1:0];
   assign lo_t = lo_ff[TIME_W-1:0];
   assign hi_t = hi_ff[TIME_W-1:0];
   assign m0   = lo_ff[WORD_W-1] ? lo_ff[WORD_W-2 -: VAL_W] : '0;
   assign m1   = hi_ff[WORD_W-1] ? hi_ff[WORD_W-2 -: VAL_W] : '0;
   assign diff = 33'(signed'(hi_ff[TIME_W +: VAL_W])) - 33'(signed'(lo_ff[TIME_W +: VAL_W]));

   assign stat.is_write = op_ff;
   assign stat.wr_index = idx_ff;
   assign stat.q_lt     = q_ff < rd_t;
   assign stat.q_eq     = q_ff == rd_t;
   assign stat.zero_len = hi_t <= lo_t;

   assign d_new   = hi_t - lo_t;
   assign tau     = ((q_ff - lo_t) > d_new) ? d_new : (q_ff - lo_t);
   assign shifted = first_ff ? rem_ff : {rem_ff[TIME_W-1:0], 1'b0};
   assign ge      = shifted >= {1'b0, d_ff};

   assign s_e  = signed'({3'b0, quo_ff});
   assign s2_e = signed'({3'b0, s2_ff});
   assign s3_e = signed'({3'b0, s3_ff});
   assign h    = (s2_e <<< 1) + s2_e - (s3_e <<< 1);
   assign g0   = s3_e - (s2_e <<< 1) + s_e;
   assign g1   = s3_e - s2_e;

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_SS: begin
            opa = signed'({5'b0, quo_ff});
            opb = signed'({5'b0, quo_ff});
         end
         MUL_S2S: begin
            opa = signed'({5'b0, s2_ff});
            opb = signed'({5'b0, quo_ff});
         end
         MUL_PH: begin
            opa = MUL_W'(diff);
            opb = MUL_W'(h);
         end
         MUL_M0G0: begin
            opa = MUL_W'(m0);
            opb = MUL_W'(g0);
         end
         MUL_M1G1: begin
            opa = MUL_W'(m1);
            opb = MUL_W'(g1);
         end
         MUL_A0D, MUL_A1D: begin
            opa = a_ff;
            opb = signed'({4'b0, d_ff});
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign prod_in = opa * opb;
   assign sh18    = prod_ff >>> 18;
   assign sh28    = prod_ff >>> 28;
   assign sh30    = prod_ff >>> 30;

   always_comb begin
      priority if (acc_ff > SAT_HI) begin
         sat = SAT_HI[VAL_W-1:0];
      end else if (acc_ff < SAT_LO) begin
         sat = SAT_LO[VAL_W-1:0];
      end else begin
         sat = acc_ff[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_tuser;
         idx_ff   <= req_tdata[KNOT_AW-1:0];
         wword_ff <= req_tdata[KNOT_AW +: WORD_W];
         q_ff     <= req_tdata[KNOT_AW + WORD_W +: TIME_W];
      end
      if (cmd.shift) begin
         lo_ff <= hi_ff;
         hi_ff <= rd_word;
      end
      if (cmd.div_init) begin
         d_ff     <= d_new;
         rem_ff   <= {1'b0, tau};
         quo_ff   <= '0;
         first_ff <= 1'b1;
      end
      if (cmd.div_step) begin
         rem_ff   <= ge ? shifted - {1'b0, d_ff} : shifted;
         quo_ff   <= {quo_ff[Q_W-2:0], ge};
         first_ff <= 1'b0;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.take_en) begin
         unique case (cmd.mul_sel)
            MUL_SS:  s2_ff <= prod_ff[30 +: Q_W];
            MUL_S2S: s3_ff <= prod_ff[30 +: Q_W];
            MUL_PH:  acc_ff <= ACC_W'(signed'(lo_ff[TIME_W +: VAL_W])) + sh30[ACC_W-1:0];
            MUL_M0G0, MUL_M1G1: a_ff <= sh28[MUL_W-1:0];
            MUL_A0D, MUL_A1D:   acc_ff <= acc_ff + sh18[ACC_W-1:0];
            default: acc_ff <= acc_ff;
         endcase
      end
      if (cmd.rsp_load) begin
         value_ff  <= cmd.rsp_use_value ? sat : '0;
         seg_ff    <= cmd.rsp_seg;
         status_ff <= cmd.rsp_status;
      end
   end

   assign rsp_tdata = {{(RSP_DATA_W - VAL_W - KNOT_AW){1'b0}}, seg_ff, value_ff};
   assign rsp_tuser = status_ff;
endmodule
`default_nettype wire

>>> design/cubic_hermite_spline_eval_unit.sv
// A knot write goes from the start state straight to the response state after it is accepted.
// An evaluate that ends in the search responds after reading 1 to 64 knots from the table;
// a full segment goes through the table reads, one check state, a restoring divider that
// yields 31 quotient bits and seven multiply-and-take passes through one shared multiplier.
// One request at a time; the next is accepted the cycle after the response is registered.
// Reset is synchronous: control clears and knot_count returns to 2; the knot table is kept.
`default_nettype none
module cubic_hermite_spline_eval_unit import chse_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CNT_W-1:0]      csr_wr_data,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // knot_index, knot_time, knot_position, knot_slope, knot_has_slope, query_time
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // spline_value, segment_index
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic      [1:0]            rsp_tuser
);
   dp_cmd_type  cmd;
   dp_stat_type stat;

   chse_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd),
      .stat        (stat)
   );

   chse_dp u_dp (
      .clock     (clock),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in progress");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[VAL_W-1:0] == '0)
      else $error("error response carries a nonzero value");
endmodule
`default_nettype wire
